// ===== hdl/brbs_pkg.sv =====
// types, codes and divider step shared by the byte range block splitter
`timescale 1ns / 1ps
package brbs_pkg;

  localparam logic [1:0] CFG_BLOCK_SIZE    = 2'd0;
  localparam logic [1:0] CFG_DEVICE_LENGTH = 2'd1;
  localparam logic [1:0] CFG_READ_ONLY     = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_RANGE     = 2'd1;
  localparam logic [1:0] ST_WPROTECT  = 2'd2;

  localparam logic [2:0] KIND_NONE    = 3'd0;
  localparam logic [2:0] KIND_PART_RD = 3'd1;
  localparam logic [2:0] KIND_PART_RMW = 3'd2;
  localparam logic [2:0] KIND_WHOLE_RD = 3'd3;
  localparam logic [2:0] KIND_WHOLE_WR = 3'd4;

  localparam logic [16:0] BS_MAX = 17'h10000;

  typedef struct packed {
    logic        wr;
    logic        single;
    logic [1:0]  status;
    logic [31:0] len;
    logic [47:0] w;       // offset dividend, then block address of the head
    logic [16:0] rem;
    logic [15:0] skip;
    logic        h_en;
    logic [31:0] head;
    logic [31:0] lw;      // body length dividend, then whole block count
    logic [31:0] bytes;
    logic [47:0] addr_b;
    logic [47:0] addr_t;
    logic [31:0] buf_t;
  } item_t;

  // four restoring division steps: returns {remainder, quotient bits}
  function automatic logic [20:0] div_step4(input logic [16:0] rem,
                                            input logic [3:0] bits,
                                            input logic [16:0] dv);
    logic [17:0] r;
    logic [3:0]  q;
    r = {1'b0, rem};
    q = '0;
    for (int k = 3; k >= 0; k--) begin
      r = {r[16:0], bits[k]};
      if (r >= {1'b0, dv}) begin
        r = r - {1'b0, dv};
        q[k] = 1'b1;
      end
    end
    return {r[16:0], q};
  endfunction

endpackage

// ===== hdl/byte_range_block_splitter_core.sv =====
// top level: byte range request to head, body and tail block commands
`timescale 1ns / 1ps
// A request (op, byte_offset, byte_length) enters a 24 stage pipeline and
// may be accepted in every cycle while the pipeline moves. The offset is
// divided by the block size four quotient bits per stage (12 stages), the
// head piece is trimmed, the remaining length is divided the same way
// (8 stages), then the body byte count and the body and tail addresses are
// formed. A request gives one to three result transactions on the single
// result port, one per cycle while the port does not stall, as set by the
// number of commands it splits into. A stalled result port holds the whole
// pipeline once its last stage is occupied, and the input stalls with it.
// Configuration writes take effect at once; the user must make them only
// while the block is idle, which the block itself does not enforce. The
// block size is stored already clamped to 1..65536.
module byte_range_block_splitter_core
  import brbs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [48:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_op,
  input  logic [47:0] in_byte_offset,
  input  logic [31:0] in_byte_length,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [2:0]  out_command_kind,
  output logic [47:0] out_block_address,
  output logic [31:0] out_block_count,
  output logic [15:0] out_byte_in_block,
  output logic [31:0] out_byte_count,
  output logic [31:0] out_buffer_offset,
  output logic        out_last
);

  localparam int NSTG         = 24;
  localparam int OFF_DIV_LAST = 12;
  localparam int HEAD_STG     = 13;
  localparam int LEN_DIV_LAST = 21;
  localparam int MUL_STG      = 22;

  // configuration registers
  logic [16:0] bs_r;
  logic [48:0] dev_len_r;
  logic        ro_r;
  logic [16:0] bs_nxt;

  always_comb begin
    bs_nxt = cfg_wdata[16:0];
    if (cfg_wdata[16:0] == 17'd0) begin
      bs_nxt = 17'd1;
    end else if (cfg_wdata[16:0] > BS_MAX) begin
      bs_nxt = BS_MAX;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bs_r      <= 17'd512;
      dev_len_r <= '0;
      ro_r      <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_BLOCK_SIZE:    bs_r      <= bs_nxt;
        CFG_DEVICE_LENGTH: dev_len_r <= cfg_wdata;
        CFG_READ_ONLY:     ro_r      <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // pipeline
  item_t             stg_r   [NSTG];
  item_t             stg_nxt [NSTG];
  logic [NSTG-1:0]   vld_r;
  logic              adv;
  logic              load;

  // result serializer
  item_t       ser_r;
  logic        ser_vld_r;
  logic [2:0]  pend_r;
  logic        out_acc;
  logic [2:0]  pend_left;

  always_comb begin
    logic [20:0] d;
    logic [16:0] hmax;
    logic [48:0] lo_sum;
    logic [48:0] prod;
    d      = '0;
    hmax   = '0;
    prod   = '0;
    lo_sum = {1'b0, in_byte_offset} + {17'd0, in_byte_length};
    stg_nxt[0]        = '0;
    stg_nxt[0].wr     = in_op;
    stg_nxt[0].len    = in_byte_length;
    stg_nxt[0].w      = in_byte_offset;
    stg_nxt[0].single = 1'b1;
    // priority: write protect, then empty, then range
    if (in_op && ro_r) begin
      stg_nxt[0].status = ST_WPROTECT;
    end else if (in_byte_length == 32'd0) begin
      stg_nxt[0].status = ST_OK;
    end else if (lo_sum > dev_len_r) begin
      stg_nxt[0].status = ST_RANGE;
    end else begin
      stg_nxt[0].status = ST_OK;
      stg_nxt[0].single = 1'b0;
    end
    for (int i = 1; i < NSTG; i++) begin
      stg_nxt[i] = stg_r[i-1];
      if (i <= OFF_DIV_LAST) begin
        d = div_step4(stg_r[i-1].rem, stg_r[i-1].w[47:44], bs_r);
        stg_nxt[i].rem = d[20:4];
        stg_nxt[i].w   = {stg_r[i-1].w[43:0], d[3:0]};
      end else if (i == HEAD_STG) begin
        hmax = bs_r - stg_r[i-1].rem;
        stg_nxt[i].skip = stg_r[i-1].rem[15:0];
        stg_nxt[i].h_en = (stg_r[i-1].rem != 17'd0);
        if (stg_r[i-1].rem == 17'd0) begin
          stg_nxt[i].head = '0;
        end else if ({15'd0, hmax} > stg_r[i-1].len) begin
          stg_nxt[i].head = stg_r[i-1].len;
        end else begin
          stg_nxt[i].head = {15'd0, hmax};
        end
        stg_nxt[i].lw  = stg_r[i-1].len - stg_nxt[i].head;
        stg_nxt[i].rem = '0;
      end else if (i <= LEN_DIV_LAST) begin
        d = div_step4(stg_r[i-1].rem, stg_r[i-1].lw[31:28], bs_r);
        stg_nxt[i].rem = d[20:4];
        stg_nxt[i].lw  = {stg_r[i-1].lw[27:0], d[3:0]};
      end else if (i == MUL_STG) begin
        prod = {17'd0, stg_r[i-1].lw} * {32'd0, bs_r};
        stg_nxt[i].bytes  = prod[31:0];
        stg_nxt[i].addr_b = stg_r[i-1].w + {47'd0, stg_r[i-1].h_en};
      end else begin
        stg_nxt[i].addr_t = stg_r[i-1].addr_b + {16'd0, stg_r[i-1].lw};
        stg_nxt[i].buf_t  = stg_r[i-1].head + stg_r[i-1].bytes;
      end
    end
  end

  // the whole pipeline moves unless its last item cannot go to the serializer
  assign out_acc   = ser_vld_r && !out_stall;
  assign pend_left = pend_r & (pend_r - 3'd1);
  assign load      = vld_r[NSTG-1] && (!ser_vld_r || (out_acc && pend_left == 3'd0));
  assign adv       = !vld_r[NSTG-1] || load;
  assign in_stall  = !adv;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < NSTG; i++) begin
        stg_r[i] <= stg_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NSTG-2:0], in_valid};
    end
  end

  // serializer: pend bit 0 head, bit 1 body, bit 2 tail
  always_ff @(posedge clk) begin
    if (load) begin
      ser_r <= stg_r[NSTG-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ser_vld_r <= 1'b0;
      pend_r    <= '0;
    end else if (load) begin
      ser_vld_r <= 1'b1;
      if (stg_r[NSTG-1].single) begin
        pend_r <= 3'b001;
      end else begin
        pend_r <= {stg_r[NSTG-1].rem != 17'd0, stg_r[NSTG-1].lw != 32'd0,
                   stg_r[NSTG-1].h_en};
      end
    end else if (out_acc) begin
      pend_r    <= pend_left;
      ser_vld_r <= (pend_left != 3'd0);
    end
  end

  // result fields for the current part
  always_comb begin
    out_valid         = ser_vld_r;
    out_last          = (pend_left == 3'd0);
    out_status        = ST_OK;
    out_command_kind  = KIND_NONE;
    out_block_address = '0;
    out_block_count   = '0;
    out_byte_in_block = '0;
    out_byte_count    = '0;
    out_buffer_offset = '0;
    if (ser_r.single) begin
      out_status = ser_r.status;
    end else if (pend_r[0]) begin
      out_command_kind  = ser_r.wr ? KIND_PART_RMW : KIND_PART_RD;
      out_block_address = ser_r.w;
      out_block_count   = 32'd1;
      out_byte_in_block = ser_r.skip;
      out_byte_count    = ser_r.head;
    end else if (pend_r[1]) begin
      out_command_kind  = ser_r.wr ? KIND_WHOLE_WR : KIND_WHOLE_RD;
      out_block_address = ser_r.addr_b;
      out_block_count   = ser_r.lw;
      out_byte_count    = ser_r.bytes;
      out_buffer_offset = ser_r.head;
    end else begin
      out_command_kind  = ser_r.wr ? KIND_PART_RMW : KIND_PART_RD;
      out_block_address = ser_r.addr_t;
      out_block_count   = 32'd1;
      out_byte_count    = {15'd0, ser_r.rem};
      out_buffer_offset = ser_r.buf_t;
    end
  end

  // checks
  a_pend_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    ser_vld_r |-> pend_r != 3'd0)
    else $error("serializer valid with no part pending");

  a_single_one_part: assert property (@(posedge clk) disable iff (!rst_n)
    ser_vld_r && ser_r.single |-> pend_r == 3'b001)
    else $error("single result transaction with more than one part");

  a_more_parts_follow: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last |=> out_valid)
    else $error("request ended without a last transaction");

  a_hold_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[NSTG-1] && !load |=> vld_r[NSTG-1])
    else $error("blocked pipeline item lost");

endmodule

// ===== bench/byte_range_block_splitter_core_tb.sv =====
// testbench for the byte range block splitter: self-checking, random idling
`timescale 1ns / 1ps
module byte_range_block_splitter_core_tb;
  import brbs_pkg::*;

  typedef struct {
    logic        op;
    logic [47:0] off;
    logic [31:0] len;
  } request_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [2:0]  kind;
    logic [47:0] lba;
    logic [31:0] cnt;
    logic [15:0] bib;
    logic [31:0] bytes;
    logic [31:0] bufo;
    logic        last;
  } block_cmd_t;

  localparam int LATENCY = 40;
  localparam int IDLE_LIMIT = 4000;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [48:0] cfg_wdata;
  logic        in_valid;
  logic        in_stall;
  logic        in_op;
  logic [47:0] in_byte_offset;
  logic [31:0] in_byte_length;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  out_status;
  logic [2:0]  out_command_kind;
  logic [47:0] out_block_address;
  logic [31:0] out_block_count;
  logic [15:0] out_byte_in_block;
  logic [31:0] out_byte_count;
  logic [31:0] out_buffer_offset;
  logic        out_last;

  byte_range_block_splitter_core u_top (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .in_op(in_op),
    .in_byte_offset(in_byte_offset), .in_byte_length(in_byte_length),
    .out_valid(out_valid), .out_stall(out_stall), .out_status(out_status),
    .out_command_kind(out_command_kind), .out_block_address(out_block_address),
    .out_block_count(out_block_count), .out_byte_in_block(out_byte_in_block),
    .out_byte_count(out_byte_count), .out_buffer_offset(out_buffer_offset),
    .out_last(out_last)
  );

  // our copy of the configuration registers
  logic [16:0] blk_size_reg;
  logic [48:0] dev_len_reg;
  logic        ro_reg;

  request_t   pending_reqs[$];
  block_cmd_t expected_cmds[$];

  int  mismatches;
  bit  in_took, out_took;
  int  send_gap, recv_wait;
  int  recv_hold_req;   // long receiver hold-off, requested by the stimulus
  int  recv_hold;
  bit  quiet;           // no random idling on either side in this phase
  int  idle_cycles;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic void push_cmd(logic [1:0] st, logic [2:0] kind, logic [63:0] lba,
                                   logic [63:0] cnt, logic [63:0] bib, logic [63:0] bytes,
                                   logic [63:0] bufo, logic last);
    block_cmd_t c;
    c.status = st;
    c.kind   = kind;
    c.lba    = lba[47:0];
    c.cnt    = cnt[31:0];
    c.bib    = bib[15:0];
    c.bytes  = bytes[31:0];
    c.bufo   = bufo[31:0];
    c.last   = last;
    expected_cmds.push_back(c);
  endfunction

  // head / whole-block body / tail split of one request
  function automatic void split_request(request_t r);
    logic [63:0] bs, off, len, skip, head, blocks, bytes, bufo;
    bs = 64'(blk_size_reg);
    if (bs == 0) bs = 1;
    if (bs > 65536) bs = 65536;
    off  = 64'(r.off);
    len  = 64'(r.len);
    bufo = 0;
    if (r.op && ro_reg) begin
      push_cmd(ST_WPROTECT, KIND_NONE, 0, 0, 0, 0, 0, 1'b1);
      return;
    end
    if (len == 0) begin
      push_cmd(ST_OK, KIND_NONE, 0, 0, 0, 0, 0, 1'b1);
      return;
    end
    if (off + len > 64'(dev_len_reg)) begin
      push_cmd(ST_RANGE, KIND_NONE, 0, 0, 0, 0, 0, 1'b1);
      return;
    end
    skip = off % bs;
    if (skip != 0) begin
      head = bs - skip;
      if (head > len) head = len;
      len = len - head;
      push_cmd(ST_OK, r.op ? KIND_PART_RMW : KIND_PART_RD, off / bs, 1, skip, head, 0,
               len == 0);
      off  = off + head;
      bufo = head;
    end
    blocks = len / bs;
    if (blocks > 0) begin
      bytes = blocks * bs;
      len = len - bytes;
      push_cmd(ST_OK, r.op ? KIND_WHOLE_WR : KIND_WHOLE_RD, off / bs, blocks, 0, bytes,
               bufo, len == 0);
      off  = off + bytes;
      bufo = bufo + bytes;
    end
    if (len > 0)
      push_cmd(ST_OK, r.op ? KIND_PART_RMW : KIND_PART_RD, off / bs, 1, 0, len, bufo, 1'b1);
  endfunction

  // sender: one valid assignment per falling edge
  always @(negedge clk) begin
    request_t r;
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else if (!in_valid || in_took) begin
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
        r = pending_reqs.pop_front();
        in_op          <= r.op;
        in_byte_offset <= r.off;
        in_byte_length <= r.len;
        in_valid       <= 1'b1;
        send_gap = quiet ? 0 : $urandom_range(0, 5);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: per-result random wait, plus the long hold-off when asked
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      recv_hold = 0;
    end else begin
      if (recv_hold_req > 0) begin
        recv_hold = recv_hold_req;
        recv_hold_req = 0;
      end
      if (recv_hold > 0) begin
        recv_hold--;
        out_stall <= 1'b1;
      end else if (recv_wait > 0) begin
        recv_wait--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // monitor: predict on input transactions, check output transactions
  always @(posedge clk) begin
    block_cmd_t got, want;
    request_t r;
    in_took  = rst_n && in_valid && !in_stall;
    out_took = rst_n && out_valid && !out_stall;
    if (in_took) begin
      r.op  = in_op;
      r.off = in_byte_offset;
      r.len = in_byte_length;
      split_request(r);
    end
    if (out_took) begin
      got = {out_status, out_command_kind, out_block_address, out_block_count,
             out_byte_in_block, out_byte_count, out_buffer_offset, out_last};
      if (expected_cmds.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected transaction: %p", got);
      end else begin
        want = expected_cmds.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: expected %p", want);
            $display("          actual   %p", got);
          end
        end
      end
      recv_wait = quiet ? 0 : $urandom_range(0, 5);
    end
    // watchdog on outstanding work with no progress
    if (in_took || out_took) idle_cycles = 0;
    else if (pending_reqs.size() > 0 || in_valid || expected_cmds.size() > 0) idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [48:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    if (idx == CFG_BLOCK_SIZE) blk_size_reg = val[16:0];
    else if (idx == CFG_DEVICE_LENGTH) dev_len_reg = val;
    else if (idx == CFG_READ_ONLY) ro_reg = val[0];
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic configure(logic [16:0] bs, logic [48:0] dl, logic ro);
    write_reg(CFG_BLOCK_SIZE, 49'(bs));
    write_reg(CFG_DEVICE_LENGTH, dl);
    write_reg(CFG_READ_ONLY, 49'(ro));
  endtask

  task automatic add_req(logic op, logic [47:0] off, logic [31:0] len);
    request_t r;
    r.op  = op;
    r.off = off;
    r.len = len;
    pending_reqs.push_back(r);
  endtask

  // everything sent, everything back, then let the pipeline settle
  task automatic drain();
    while (pending_reqs.size() > 0 || in_valid || expected_cmds.size() > 0)
      @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  // random request, mostly inside the device so splitting is exercised
  task automatic add_random_req();
    logic [63:0] bs, dl, off, room, cap, len;
    int pick;
    bs = (blk_size_reg == 0) ? 1 : (blk_size_reg > 65536 ? 65536 : 64'(blk_size_reg));
    dl = 64'(dev_len_reg);
    pick = $urandom_range(0, 9);
    if (pick < 7 && dl > 0) begin
      off  = rand64() % dl;
      off  = (off > 64'hFFFF_FFFF_FFFF) ? 64'hFFFF_FFFF_FFFF : off;
      room = dl - off;
      cap  = ($urandom_range(0, 3) == 0) ? 64'hFFFF_FFFF : 4 * bs;
      if (cap > room) cap = room;
      if ($urandom_range(0, 3) == 0) off = off - (off % bs);   // aligned start
      len = 1 + rand64() % cap;
      if (off + len > dl) len = dl - off;
      add_req($urandom_range(0, 1), off[47:0], len[31:0]);
    end else if (pick == 7) begin
      add_req($urandom_range(0, 1), rand64(), 32'd0);
    end else if (pick == 8 && dl < 64'h1_0000_0000_0000) begin
      off = dl - (rand64() % (dl + 1));
      add_req($urandom_range(0, 1), off[47:0], 32'(dl - off + 1 + $urandom_range(0, 9)));
    end else begin
      add_req($urandom_range(0, 1), rand64(), $urandom);
    end
  endtask

  initial begin
    logic [16:0] bs_pick;
    logic [48:0] dl_pick;
    mismatches    = 0;
    idle_cycles   = 0;
    recv_wait     = 0;
    recv_hold_req = 0;
    quiet         = 1'b0;
    blk_size_reg  = 17'd512;
    dev_len_reg   = '0;
    ro_reg        = 1'b0;
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = CFG_BLOCK_SIZE;
    cfg_wdata      = '0;
    in_valid       = 1'b0;
    in_op          = 1'b0;
    in_byte_offset = '0;
    in_byte_length = '0;
    out_stall      = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset values: device length zero, so only zero lengths pass
    add_req(1'b0, 48'd0, 32'd0);
    add_req(1'b1, 48'd0, 32'd1);
    drain();

    // directed splits on 512 byte blocks
    configure(17'd512, 49'd1 << 20, 1'b0);
    add_req(1'b0, 48'd0, 32'd0);           // empty request
    add_req(1'b0, 48'd0, 32'd1024);        // whole blocks only
    add_req(1'b1, 48'd0, 32'd1024);
    add_req(1'b0, 48'd10, 32'd20);         // head inside one block
    add_req(1'b1, 48'd10, 32'd502);        // head ending on a boundary
    add_req(1'b0, 48'd100, 32'd2000);      // head, body and tail
    add_req(1'b1, 48'd100, 32'd2000);
    add_req(1'b0, 48'd512, 32'd700);       // body and tail
    add_req(1'b1, 48'd500, 32'd100);       // head and tail, no body
    add_req(1'b0, 48'd1024, 32'd5);        // tail only
    add_req(1'b0, 48'd1048575, 32'd1);     // last byte of the device
    add_req(1'b1, 48'd1048575, 32'd2);     // one byte past the end
    add_req(1'b0, 48'hFFFF_FFFF_FFFF, 32'd1);
    add_req(1'b0, 48'd0, 32'hFFFF_FFFF);
    drain();

    // read-only device: writes rejected, zero length too
    configure(17'd512, 49'd1 << 20, 1'b1);
    add_req(1'b1, 48'd0, 32'd0);
    add_req(1'b1, 48'd100, 32'd2000);
    add_req(1'b0, 48'd100, 32'd2000);
    add_req(1'b1, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF);
    drain();

    // extremes: block size zero (clamped to one), saturation, largest device
    configure(17'd0, 49'h1_0000_0000_0000, 1'b0);
    add_req(1'b0, 48'd3, 32'd7);
    add_req(1'b1, 48'hFFFF_FFFF_0000, 32'hFFFF_FFFF);
    drain();
    configure(17'h1FFFF, 49'h1_FFFF_FFFF_FFFF, 1'b0);
    add_req(1'b0, 48'd65535, 32'd65538);
    add_req(1'b1, 48'hFFFF_FFFF_FFFF, 32'd1);
    add_req(1'b0, 48'hFFFF_0000_0001, 32'hFFFF_FFFF);
    drain();

    // long receiver hold-off while the sender keeps going
    configure(17'd4096, 49'd1 << 40, 1'b0);
    quiet = 1'b1;
    recv_hold_req = 300;
    repeat (60) add_random_req();
    drain();
    quiet = 1'b0;

    // random phases across block sizes and device lengths
    for (int phase = 0; phase < 14; phase++) begin
      case ($urandom_range(0, 7))
        0: bs_pick = 17'd0;
        1: bs_pick = 17'd1;
        2: bs_pick = 17'd3;
        3: bs_pick = 17'd512;
        4: bs_pick = 17'h10000;
        5: bs_pick = 17'h1FFFF;
        default: bs_pick = 17'($urandom);
      endcase
      case ($urandom_range(0, 4))
        0: dl_pick = 49'h1_0000_0000_0000;
        1: dl_pick = 49'h1_FFFF_FFFF_FFFF;
        2: dl_pick = 49'($urandom_range(0, 100000));
        default: dl_pick = 49'(rand64());
      endcase
      configure(bs_pick, dl_pick, $urandom_range(0, 3) == 0);
      quiet = ($urandom_range(0, 3) == 0);
      repeat (30) add_random_req();
      drain();
    end
    quiet = 1'b0;

    mismatches += expected_cmds.size();
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
